>>> design/ordered_dither_color_cube_pen_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered dither color cube pen block
// Concurrent checks on one clock with an active-low reset; NO_ASSERTIONS
// compiles them out.
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_COLOR_CUBE_PEN_DEFINES_SVH
`define ORDERED_DITHER_COLOR_CUBE_PEN_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ODCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odcp same-cycle check failed");

// Next-cycle implication.
`define ODCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odcp next-cycle check failed");

`else

`define ODCP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ODCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/odcp_pkg.sv
// ----------------------------------------------------------------------------
// odcp_pkg
// Shared types, constants and the Bayer threshold table of the ordered
// dither color cube pen block.
// ----------------------------------------------------------------------------
package odcp_pkg;

    localparam int CHAN_W      = 8;
    localparam int STEP_W      = 8;
    localparam int LEVEL_W     = 3;
    localparam int PEN_W       = 8;
    localparam int SLOT_W      = 8;
    localparam int PHASE_W     = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CUBE_IDX_W  = 9;   // largest cube index is 342 (level count seven)
    localparam int PROD_W      = 2 * LEVEL_W;
    localparam int THRESH_W    = 2 * CHAN_W;

    localparam int PEN_TABLE_DEPTH_DEF = 256;

    // Two quotient bits per divider stage
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = CHAN_W / DIV_BITS_PER_STAGE;

    localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 8'd51;
    localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RST = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE   = 1'b0,
        CFG_LEVEL_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_DITHER = 1'b1
    } op_t;

    typedef struct packed {
        logic               operation;
        logic [SLOT_W-1:0]  pen_slot;
        logic [PEN_W-1:0]   pen_value;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [PHASE_W-1:0] column_phase;
        logic [PHASE_W-1:0] row_phase;
    } pixel_beat_t;

    typedef struct packed {
        logic [PEN_W-1:0] pen;
        logic [PEN_W-1:0] mirror_pen;
    } result_beat_t;

    // 16x16 threshold matrix, indexed [row][column]
    localparam logic [7:0] BAYER_MATRIX [0:15][0:15] = '{
        '{8'd1,   8'd235, 8'd59,  8'd219, 8'd15,  8'd231, 8'd55,  8'd215,
          8'd2,   8'd232, 8'd56,  8'd216, 8'd12,  8'd228, 8'd52,  8'd212},
        '{8'd129, 8'd65,  8'd187, 8'd123, 8'd143, 8'd79,  8'd183, 8'd119,
          8'd130, 8'd66,  8'd184, 8'd120, 8'd140, 8'd76,  8'd180, 8'd116},
        '{8'd33,  8'd193, 8'd17,  8'd251, 8'd47,  8'd207, 8'd31,  8'd247,
          8'd34,  8'd194, 8'd18,  8'd248, 8'd44,  8'd204, 8'd28,  8'd244},
        '{8'd161, 8'd97,  8'd145, 8'd81,  8'd175, 8'd111, 8'd159, 8'd95,
          8'd162, 8'd98,  8'd146, 8'd82,  8'd172, 8'd108, 8'd156, 8'd92},
        '{8'd9,   8'd225, 8'd49,  8'd209, 8'd5,   8'd239, 8'd63,  8'd223,
          8'd10,  8'd226, 8'd50,  8'd210, 8'd6,   8'd236, 8'd60,  8'd220},
        '{8'd137, 8'd73,  8'd177, 8'd113, 8'd133, 8'd69,  8'd191, 8'd127,
          8'd138, 8'd74,  8'd178, 8'd114, 8'd134, 8'd70,  8'd188, 8'd124},
        '{8'd41,  8'd201, 8'd25,  8'd241, 8'd37,  8'd197, 8'd21,  8'd254,
          8'd42,  8'd202, 8'd26,  8'd242, 8'd38,  8'd198, 8'd22,  8'd252},
        '{8'd169, 8'd105, 8'd153, 8'd89,  8'd165, 8'd101, 8'd149, 8'd85,
          8'd170, 8'd106, 8'd154, 8'd90,  8'd166, 8'd102, 8'd150, 8'd86},
        '{8'd3,   8'd233, 8'd57,  8'd217, 8'd13,  8'd229, 8'd53,  8'd213,
          8'd0,   8'd234, 8'd58,  8'd218, 8'd14,  8'd230, 8'd54,  8'd214},
        '{8'd131, 8'd67,  8'd185, 8'd121, 8'd141, 8'd77,  8'd181, 8'd117,
          8'd128, 8'd64,  8'd186, 8'd122, 8'd142, 8'd78,  8'd182, 8'd118},
        '{8'd35,  8'd195, 8'd19,  8'd249, 8'd45,  8'd205, 8'd29,  8'd245,
          8'd32,  8'd192, 8'd16,  8'd250, 8'd46,  8'd206, 8'd30,  8'd246},
        '{8'd163, 8'd99,  8'd147, 8'd83,  8'd173, 8'd109, 8'd157, 8'd93,
          8'd160, 8'd96,  8'd144, 8'd80,  8'd174, 8'd110, 8'd158, 8'd94},
        '{8'd11,  8'd227, 8'd51,  8'd211, 8'd7,   8'd237, 8'd61,  8'd221,
          8'd8,   8'd224, 8'd48,  8'd208, 8'd4,   8'd238, 8'd62,  8'd222},
        '{8'd139, 8'd75,  8'd179, 8'd115, 8'd135, 8'd71,  8'd189, 8'd125,
          8'd136, 8'd72,  8'd176, 8'd112, 8'd132, 8'd68,  8'd190, 8'd126},
        '{8'd43,  8'd203, 8'd27,  8'd243, 8'd39,  8'd199, 8'd23,  8'd253,
          8'd40,  8'd200, 8'd24,  8'd240, 8'd36,  8'd196, 8'd20,  8'd254},
        '{8'd171, 8'd107, 8'd155, 8'd91,  8'd167, 8'd103, 8'd151, 8'd87,
          8'd168, 8'd104, 8'd152, 8'd88,  8'd164, 8'd100, 8'd148, 8'd84}
    };

endpackage

>>> design/odcp_pen_mem.sv
// ----------------------------------------------------------------------------
// odcp_pen_mem
// Pen table: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module odcp_pen_mem #(
    parameter int DEPTH  = odcp_pkg::PEN_TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [odcp_pkg::PEN_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr_a,
    input  logic [ADDR_W-1:0]           raddr_b,
    output logic [odcp_pkg::PEN_W-1:0]  rdata_a,
    output logic [odcp_pkg::PEN_W-1:0]  rdata_b
);

    logic [odcp_pkg::PEN_W-1:0] mem [DEPTH];

    // Read returns the old contents on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> design/ordered_dither_color_cube_pen.sv
// ----------------------------------------------------------------------------
// ordered_dither_color_cube_pen
// Ordered 16x16 dither of an RGB pixel onto a color cube, then pen lookup.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel (valid/ready): a beat either writes one pen table entry
//   (operation write) or dithers one pixel (operation dither). A write
//   beat produces nothing on the result channel; a dither beat produces
//   exactly one result beat carrying pen and mirror_pen, in order.
//   cfg port: step_size (index 0) and level_count (index 1), written with
//   cfg_we while the block is idle; no handshake, no read-back.
// Throughput and pipeline:
//   One beat per cycle sustained while result_ready stays high: the path
//   is eight register stages (entry with threshold multiply, four radix-4
//   divider stages, level, scale, cube index) plus the registered read of
//   the two-port pen memory.
// Reset:
//   step_size returns to 51, level_count to 6, the pipeline empties. The
//   pen table is not cleared; entries hold garbage until written.
// Stall:
//   A stalled result holds in the output register. Upstream stages keep
//   filling bubbles; pixel_ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
`include "ordered_dither_color_cube_pen_defines.svh"

module ordered_dither_color_cube_pen #(
    parameter int PEN_TABLE_DEPTH = odcp_pkg::PEN_TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [odcp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [odcp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  odcp_pkg::pixel_beat_t               pixel,
    output logic                                result_valid,
    input  logic                                result_ready,
    output odcp_pkg::result_beat_t              result
);

    localparam int ADDR_W   = $clog2(PEN_TABLE_DEPTH);
    localparam int IDX_W    = odcp_pkg::CUBE_IDX_W;
    localparam int NUM_CH   = 3;
    localparam int CH_R     = 0;
    localparam int CH_G     = 1;
    localparam int CH_B     = 2;
    localparam int LVL_STG  = odcp_pkg::DIV_STAGES + 1;
    localparam int MUL_STG  = LVL_STG + 1;
    localparam int ADR_STG  = MUL_STG + 1;
    localparam int OUT_STG  = ADR_STG + 1;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(PEN_TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] DEPTH_LIM = IDX_W'(PEN_TABLE_DEPTH);

    typedef struct packed {
        logic                           is_pixel;
        logic [odcp_pkg::SLOT_W-1:0]    slot;
        logic [odcp_pkg::PEN_W-1:0]     value;
    } item_t;

    typedef struct packed {
        logic [odcp_pkg::CHAN_W-1:0]    rem;
        logic [odcp_pkg::CHAN_W-1:0]    quo;
        logic [odcp_pkg::CHAN_W-1:0]    dvd;
    } div_lane_t;

    typedef struct packed {
        item_t                          item;
        div_lane_t [NUM_CH-1:0]         lanes;
        logic [odcp_pkg::THRESH_W-1:0]  prod;
        logic [odcp_pkg::CHAN_W-1:0]    thr;
    } div_stage_t;

    typedef struct packed {
        item_t                                      item;
        logic [NUM_CH-1:0][odcp_pkg::LEVEL_W-1:0]   lvl;
    } lvl_stage_t;

    typedef struct packed {
        item_t                                      item;
        logic [NUM_CH-1:0][odcp_pkg::LEVEL_W-1:0]   lvl;
        logic [NUM_CH-1:0][odcp_pkg::PROD_W-1:0]    mul;
    } mul_stage_t;

    typedef struct packed {
        item_t              item;
        logic [ADDR_W-1:0]  pen_addr;
        logic [ADDR_W-1:0]  mir_addr;
    } adr_stage_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [odcp_pkg::STEP_W-1:0]    step_size_reg;
    logic [odcp_pkg::LEVEL_W-1:0]   level_count_reg;
    logic [odcp_pkg::STEP_W-1:0]    s_eff;
    logic [odcp_pkg::LEVEL_W-1:0]   lv_m1;
    logic [odcp_pkg::LEVEL_W-1:0]   lv_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg   <= odcp_pkg::STEP_SIZE_RST;
            level_count_reg <= odcp_pkg::LEVEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                odcp_pkg::CFG_STEP_SIZE:
                begin
                    step_size_reg <= cfg_data[odcp_pkg::STEP_W-1:0];
                end
                odcp_pkg::CFG_LEVEL_COUNT:
                begin
                    level_count_reg <= cfg_data[odcp_pkg::LEVEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Zero step acts as one; fewer than two levels collapse the cube to one entry
    assign s_eff  = (step_size_reg == '0) ? odcp_pkg::STEP_W'(1) : step_size_reg;
    assign lv_m1  = (level_count_reg < odcp_pkg::LEVEL_W'(2)) ? '0
                                      : level_count_reg - odcp_pkg::LEVEL_W'(1);
    assign lv_eff = lv_m1 + odcp_pkg::LEVEL_W'(1);

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------

    // Restoring division, two quotient bits per call
    function automatic div_lane_t div_step(div_lane_t a, logic [odcp_pkg::STEP_W-1:0] s);
        div_lane_t                      o;
        logic [odcp_pkg::CHAN_W:0]      cand;
        o = a;
        for (int k = 0; k < odcp_pkg::DIV_BITS_PER_STAGE; k++)
        begin
            cand  = {o.rem, o.dvd[odcp_pkg::CHAN_W-1]};
            o.dvd = {o.dvd[odcp_pkg::CHAN_W-2:0], 1'b0};
            if (cand >= {1'b0, s})
            begin
                o.rem = odcp_pkg::CHAN_W'(cand - {1'b0, s});
                o.quo = {o.quo[odcp_pkg::CHAN_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = cand[odcp_pkg::CHAN_W-1:0];
                o.quo = {o.quo[odcp_pkg::CHAN_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // x / 255 for x below 65280, where the quotient fits eight bits: (x + (x >> 8) + 1) >> 8
    function automatic logic [odcp_pkg::CHAN_W-1:0] div_full_scale(
        logic [odcp_pkg::THRESH_W-1:0] x);
        logic [odcp_pkg::THRESH_W:0] sum;
        sum = {1'b0, x} + (odcp_pkg::THRESH_W+1)'(x >> odcp_pkg::CHAN_W)
                        + (odcp_pkg::THRESH_W+1)'(1);
        return sum[odcp_pkg::THRESH_W-1:odcp_pkg::CHAN_W];
    endfunction

    // Round up when the remainder beats the threshold, then clamp to the top level
    function automatic logic [odcp_pkg::LEVEL_W-1:0] chan_level(
        div_lane_t                      d,
        logic [odcp_pkg::CHAN_W-1:0]    thr,
        logic [odcp_pkg::LEVEL_W-1:0]   top);
        logic [odcp_pkg::CHAN_W:0] up;
        up = {1'b0, d.quo} + (odcp_pkg::CHAN_W+1)'(d.rem > thr);
        if (up > (odcp_pkg::CHAN_W+1)'(top))
        begin
            return top;
        end
        return up[odcp_pkg::LEVEL_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] sat_addr(logic [IDX_W-1:0] idx);
        if (idx > IDX_LAST)
        begin
            return ADDR_W'(IDX_LAST);
        end
        return ADDR_W'(idx);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: a stage takes a beat when it is empty or its
    // contents move on; write beats leave at the address stage.
    // ------------------------------------------------------------------
    div_stage_t             div_reg [0:odcp_pkg::DIV_STAGES];
    lvl_stage_t             lvl_reg;
    mul_stage_t             mul_reg;
    adr_stage_t             adr_reg;
    logic [ADR_STG:0]       vld_reg;
    logic [OUT_STG:0]       take;
    logic                   result_valid_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;

    always_comb
    begin
        take[OUT_STG] = !result_valid_reg || result_ready;
        take[ADR_STG] = !vld_reg[ADR_STG] || !adr_reg.item.is_pixel || take[OUT_STG];
        for (int i = ADR_STG - 1; i >= 0; i--)
        begin
            take[i] = !vld_reg[i] || take[i+1];
        end
    end

    assign pixel_ready = take[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take[0])
            begin
                vld_reg[0] <= pixel_valid;
            end
            for (int i = 1; i <= ADR_STG; i++)
            begin
                if (take[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (take[OUT_STG])
            begin
                result_valid_reg <= vld_reg[ADR_STG] && adr_reg.item.is_pixel;
            end
        end
    end

    // ------------------------------------------------------------------
    // Entry stage: latch the beat, look up and scale the threshold.
    // Divider stages: value / step for all three channels; the first one
    // also finishes the threshold (product / 255)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            div_reg[0].item.is_pixel    <= (pixel.operation == odcp_pkg::OP_DITHER);
            div_reg[0].item.slot        <= pixel.pen_slot;
            div_reg[0].item.value       <= pixel.pen_value;
            div_reg[0].lanes[CH_R]      <= '{rem: '0, quo: '0, dvd: pixel.red};
            div_reg[0].lanes[CH_G]      <= '{rem: '0, quo: '0, dvd: pixel.green};
            div_reg[0].lanes[CH_B]      <= '{rem: '0, quo: '0, dvd: pixel.blue};
            div_reg[0].prod             <=
                odcp_pkg::THRESH_W'(odcp_pkg::BAYER_MATRIX[pixel.row_phase][pixel.column_phase])
                * odcp_pkg::THRESH_W'(s_eff);
            div_reg[0].thr              <= '0;
        end
        for (int i = 1; i <= odcp_pkg::DIV_STAGES; i++)
        begin
            if (take[i])
            begin
                div_reg[i].item <= div_reg[i-1].item;
                div_reg[i].prod <= div_reg[i-1].prod;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    div_reg[i].lanes[c] <= div_step(div_reg[i-1].lanes[c], s_eff);
                end
                if (i == 1)
                begin
                    div_reg[i].thr <= div_full_scale(div_reg[i-1].prod);
                end
                else
                begin
                    div_reg[i].thr <= div_reg[i-1].thr;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Level, scale and cube index stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take[LVL_STG])
        begin
            lvl_reg.item <= div_reg[odcp_pkg::DIV_STAGES].item;
            for (int c = 0; c < NUM_CH; c++)
            begin
                lvl_reg.lvl[c] <= chan_level(div_reg[odcp_pkg::DIV_STAGES].lanes[c],
                                             div_reg[odcp_pkg::DIV_STAGES].thr, lv_m1);
            end
        end
        if (take[MUL_STG])
        begin
            mul_reg.item <= lvl_reg.item;
            mul_reg.lvl  <= lvl_reg.lvl;
            for (int c = 0; c < NUM_CH; c++)
            begin
                mul_reg.mul[c] <= odcp_pkg::PROD_W'(lvl_reg.lvl[c])
                                  * odcp_pkg::PROD_W'(lv_eff);
            end
        end
        if (take[ADR_STG])
        begin
            adr_reg.item     <= mul_reg.item;
            // r*L*L + g*L + b, and the same with green and blue swapped
            adr_reg.pen_addr <= sat_addr(IDX_W'(mul_reg.mul[CH_R]) * IDX_W'(lv_eff)
                                         + IDX_W'(mul_reg.mul[CH_G])
                                         + IDX_W'(mul_reg.lvl[CH_B]));
            adr_reg.mir_addr <= sat_addr(IDX_W'(mul_reg.mul[CH_R]) * IDX_W'(lv_eff)
                                         + IDX_W'(mul_reg.mul[CH_B])
                                         + IDX_W'(mul_reg.lvl[CH_G]));
        end
    end

    // ------------------------------------------------------------------
    // Pen table access: writes and reads both happen at the address stage,
    // so they reach the memory in beat order and need no forwarding.
    // Drop writes aimed past the table.
    // ------------------------------------------------------------------
    assign mem_we    = vld_reg[ADR_STG] && !adr_reg.item.is_pixel
                       && (IDX_W'(adr_reg.item.slot) < DEPTH_LIM);
    assign mem_waddr = ADDR_W'(adr_reg.item.slot);

    odcp_pen_mem #(
        .DEPTH  (PEN_TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_pen_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (adr_reg.item.value),
        .re      (take[OUT_STG]),
        .raddr_a (adr_reg.pen_addr),
        .raddr_b (adr_reg.mir_addr),
        .rdata_a (result.pen),
        .rdata_b (result.mirror_pen)
    );

    assign result_valid = result_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ODCP_ASSERT_NEXT(a_out_src, clk, rst_n, take[OUT_STG] && !(vld_reg[ADR_STG] && adr_reg.item.is_pixel), !result_valid_reg)
    `ODCP_ASSERT_NEXT(a_adr_hold, clk, rst_n, vld_reg[ADR_STG] && !take[ADR_STG], vld_reg[ADR_STG] && $stable(adr_reg.pen_addr) && $stable(adr_reg.mir_addr))
    `ODCP_ASSERT_NEXT(a_rem_bound, clk, rst_n, vld_reg[odcp_pkg::DIV_STAGES-1] && take[odcp_pkg::DIV_STAGES], div_reg[odcp_pkg::DIV_STAGES].lanes[CH_R].rem < $past(s_eff) && div_reg[odcp_pkg::DIV_STAGES].lanes[CH_G].rem < $past(s_eff) && div_reg[odcp_pkg::DIV_STAGES].lanes[CH_B].rem < $past(s_eff))
    `ODCP_ASSERT_NEXT(a_level_clamp, clk, rst_n, vld_reg[LVL_STG-1] && take[LVL_STG], lvl_reg.lvl[CH_R] <= $past(lv_m1) && lvl_reg.lvl[CH_G] <= $past(lv_m1) && lvl_reg.lvl[CH_B] <= $past(lv_m1))
    `ODCP_ASSERT_NOW(a_we_no_read, clk, rst_n, mem_we, !adr_reg.item.is_pixel && take[ADR_STG])

endmodule

>>> tb/odcp_pen_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// odcp_pen_checker
// Watches the configuration port and both beat channels of the ordered dither
// color cube pen block, keeps a shadow pen table, predicts pen and mirror_pen
// for every accepted pixel and checks each result beat in order.
// ----------------------------------------------------------------------------
module odcp_pen_checker #(
    parameter int PEN_TABLE_DEPTH = odcp_pkg::PEN_TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [odcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [odcp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            pixel_valid,
    input  logic                            pixel_ready,
    input  odcp_pkg::pixel_beat_t           pixel,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  odcp_pkg::result_beat_t          result,
    output int                              errors,
    output int                              pending,
    output int                              checked
);

    localparam int ADDR_W = $clog2(PEN_TABLE_DEPTH);

    logic [odcp_pkg::PEN_W-1:0]   pen_copy [PEN_TABLE_DEPTH];
    logic [odcp_pkg::STEP_W-1:0]  step_reg;
    logic [odcp_pkg::LEVEL_W-1:0] level_reg;
    odcp_pkg::result_beat_t       due_pens [$];
    odcp_pkg::result_beat_t       want;
    int                           mismatch_count = 0;
    int                           checked_count  = 0;

    assign errors  = mismatch_count;
    assign checked = checked_count;

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Level of one channel: round up past the scaled threshold, clamp to top
    function automatic logic [odcp_pkg::LEVEL_W-1:0] quantize(
        input logic [odcp_pkg::CHAN_W-1:0]  v,
        input logic [odcp_pkg::STEP_W-1:0]  s,
        input logic [odcp_pkg::CHAN_W-1:0]  thr,
        input logic [odcp_pkg::LEVEL_W-1:0] lv
    );
        logic [odcp_pkg::CHAN_W:0]   q;
        logic [odcp_pkg::CHAN_W-1:0] frac;
        logic [odcp_pkg::CHAN_W:0]   top;
        q    = {1'b0, v / s};
        frac = v % s;
        top  = {{(odcp_pkg::CHAN_W + 1 - odcp_pkg::LEVEL_W){1'b0}}, lv} - 1'b1;
        if (frac > thr)
            q = q + 1'b1;
        if (q > top)
            q = top;
        return q[odcp_pkg::LEVEL_W-1:0];
    endfunction

    // Cube index a*L*L + m*L + n, saturated to the last table entry
    function automatic logic [odcp_pkg::PEN_W-1:0] table_pen(
        input logic [odcp_pkg::LEVEL_W-1:0] a,
        input logic [odcp_pkg::LEVEL_W-1:0] m,
        input logic [odcp_pkg::LEVEL_W-1:0] n,
        input logic [odcp_pkg::LEVEL_W-1:0] lv
    );
        logic [odcp_pkg::CUBE_IDX_W-1:0] idx;
        idx = odcp_pkg::CUBE_IDX_W'(a) * odcp_pkg::CUBE_IDX_W'(lv) * odcp_pkg::CUBE_IDX_W'(lv)
            + odcp_pkg::CUBE_IDX_W'(m) * odcp_pkg::CUBE_IDX_W'(lv) + odcp_pkg::CUBE_IDX_W'(n);
        if (idx >= PEN_TABLE_DEPTH)
            idx = odcp_pkg::CUBE_IDX_W'(PEN_TABLE_DEPTH - 1);
        return pen_copy[ADDR_W'(idx)];
    endfunction

    function automatic odcp_pkg::result_beat_t predict_pens(input odcp_pkg::pixel_beat_t px);
        logic [odcp_pkg::STEP_W-1:0]   s;
        logic [odcp_pkg::LEVEL_W-1:0]  lv;
        logic [odcp_pkg::THRESH_W-1:0] prod;
        logic [odcp_pkg::CHAN_W-1:0]   thr;
        logic [odcp_pkg::LEVEL_W-1:0]  r;
        logic [odcp_pkg::LEVEL_W-1:0]  g;
        logic [odcp_pkg::LEVEL_W-1:0]  b;
        odcp_pkg::result_beat_t        res;
        // zero step acts as one; zero levels act as a single level
        s    = (step_reg == '0) ? odcp_pkg::STEP_W'(1) : step_reg;
        lv   = (level_reg == '0) ? odcp_pkg::LEVEL_W'(1) : level_reg;
        prod = odcp_pkg::THRESH_W'(odcp_pkg::BAYER_MATRIX[px.row_phase][px.column_phase])
               * odcp_pkg::THRESH_W'(s);
        thr  = odcp_pkg::CHAN_W'(prod / odcp_pkg::THRESH_W'(255));
        r    = quantize(px.red, s, thr, lv);
        g    = quantize(px.green, s, thr, lv);
        b    = quantize(px.blue, s, thr, lv);
        res.pen        = table_pen(r, g, b, lv);
        res.mirror_pen = table_pen(r, b, g, lv);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= odcp_pkg::STEP_SIZE_RST;
            level_reg <= odcp_pkg::LEVEL_COUNT_RST;
            due_pens.delete();
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    odcp_pkg::CFG_STEP_SIZE:   step_reg  <= cfg_data;
                    odcp_pkg::CFG_LEVEL_COUNT: level_reg <= cfg_data[odcp_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end
            // check against what was outstanding before this edge
            if (result_valid && result_ready)
            begin
                if (due_pens.size() == 0)
                    note_mismatch("result beat with no pixel outstanding");
                else
                begin
                    want = due_pens.pop_front();
                    checked_count++;
                    if (result.pen !== want.pen)
                        note_mismatch($sformatf("pen got %02h expected %02h",
                                                result.pen, want.pen));
                    if (result.mirror_pen !== want.mirror_pen)
                        note_mismatch($sformatf("mirror_pen got %02h expected %02h",
                                                result.mirror_pen, want.mirror_pen));
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                if (pixel.operation == odcp_pkg::OP_DITHER)
                    due_pens.push_back(predict_pens(pixel));
                else if (pixel.pen_slot < PEN_TABLE_DEPTH)
                    pen_copy[ADDR_W'(pixel.pen_slot)] = pixel.pen_value;
            end
            pending <= due_pens.size();
        end
    end

endmodule

>>> tb/ordered_dither_color_cube_pen_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_dither_color_cube_pen_tb
// Drives pen table writes and pixels into the ordered dither color cube pen
// block under a range of step size and level count settings, with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ordered_dither_color_cube_pen_tb;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_IDLE     = 16;
    // pipeline is eight stages deep; leave margin before touching config
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 98;
    localparam int PLAN_LEN     = 7;

    // Register settings walked after the reset setting: level seven with a
    // step that saturates the cube index, extremes of both registers, then
    // a couple of ordinary cubes.
    localparam logic [odcp_pkg::STEP_W-1:0]  STEP_PLAN  [PLAN_LEN] = '{8'd42, 8'd1, 8'd0,
                                                         8'd255, 8'd255, 8'd85, 8'd127};
    localparam logic [odcp_pkg::LEVEL_W-1:0] LEVEL_PLAN [PLAN_LEN] = '{3'd7, 3'd2, 3'd0,
                                                         3'd1, 3'd7, 3'd4, 3'd3};

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_we       = 1'b0;
    logic [odcp_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [odcp_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            pixel_valid  = 1'b0;
    logic                            pixel_ready;
    odcp_pkg::pixel_beat_t           pixel        = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    odcp_pkg::result_beat_t          result;

    int errors;
    int pending;
    int checked;
    int cycle_count   = 0;
    int pixels_sent   = 0;
    int writes_sent   = 0;
    int settings_used = 1;
    bit steady_send   = 1'b0;
    bit steady_recv   = 1'b0;

    ordered_dither_color_cube_pen #(
        .PEN_TABLE_DEPTH (odcp_pkg::PEN_TABLE_DEPTH_DEF)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    odcp_pen_checker #(
        .PEN_TABLE_DEPTH (odcp_pkg::PEN_TABLE_DEPTH_DEF)
    ) pen_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog: a hung handshake or a result that never shows ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: stall for a random while, up to MAX_IDLE, before taking each beat. Ready is only
    // dropped at the edge right after a beat is taken, so it never sees two
    // updates in one step. Now and then switch to a no-stall stretch.
    initial
    begin
        int stall;
        forever
        begin
            stall = steady_recv ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
            if ($urandom_range(0, 31) == 0)
                steady_recv = !steady_recv;
        end
    end

    function automatic odcp_pkg::pixel_beat_t make_beat(
        input odcp_pkg::op_t                op,
        input logic [odcp_pkg::SLOT_W-1:0]  slot,
        input logic [odcp_pkg::PEN_W-1:0]   value,
        input logic [odcp_pkg::CHAN_W-1:0]  r,
        input logic [odcp_pkg::CHAN_W-1:0]  g,
        input logic [odcp_pkg::CHAN_W-1:0]  b,
        input logic [odcp_pkg::PHASE_W-1:0] col,
        input logic [odcp_pkg::PHASE_W-1:0] row
    );
        odcp_pkg::pixel_beat_t beat;
        beat.operation    = op;
        beat.pen_slot     = slot;
        beat.pen_value    = value;
        beat.red          = r;
        beat.green        = g;
        beat.blue         = b;
        beat.column_phase = col;
        beat.row_phase    = row;
        return beat;
    endfunction

    // Lean on the ends of the channel range, where rounding and clamping bite
    function automatic logic [odcp_pkg::CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return odcp_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    function automatic odcp_pkg::pixel_beat_t random_beat();
        odcp_pkg::op_t op;
        op = ($urandom_range(0, 9) < 3) ? odcp_pkg::OP_WRITE : odcp_pkg::OP_DITHER;
        return make_beat(op, odcp_pkg::SLOT_W'($urandom), odcp_pkg::PEN_W'($urandom),
                         pick_channel(), pick_channel(), pick_channel(),
                         odcp_pkg::PHASE_W'($urandom), odcp_pkg::PHASE_W'($urandom));
    endfunction

    // Send one beat on the pixel channel after a random gap. Valid is left
    // high after acceptance; the next call drops it only if it idles, so a
    // back-to-back beat never lowers and raises valid in the same step.
    task automatic push_beat(input odcp_pkg::pixel_beat_t beat);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel       <= beat;
        pixel_valid <= 1'b1;
        do @(posedge clk); while (!pixel_ready);
        if (beat.operation == odcp_pkg::OP_DITHER)
            pixels_sent++;
        else
            writes_sent++;
        if ($urandom_range(0, 31) == 0)
            steady_send = !steady_send;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            push_beat(random_beat());
    endtask

    // Hold the pixel channel until every predicted result has come back,
    // then give write beats still in flight time to leave the pipeline.
    // The first edge lets the checker's count catch up with the last beat.
    task automatic settle();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive edges while the block is idle.
    // Junk rides in the unused upper bits of the level count write.
    task automatic write_settings(input logic [odcp_pkg::STEP_W-1:0] step,
                                  input logic [odcp_pkg::LEVEL_W-1:0] lv);
        cfg_we    <= 1'b1;
        cfg_index <= odcp_pkg::CFG_STEP_SIZE;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= odcp_pkg::CFG_LEVEL_COUNT;
        cfg_data  <= {(odcp_pkg::CFG_DATA_W - odcp_pkg::LEVEL_W)'($urandom), lv};
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole pen table first: its contents are undefined until
        // written, so no pixel may look up an entry before this completes.
        for (int slot = 0; slot < odcp_pkg::PEN_TABLE_DEPTH_DEF; slot++)
            push_beat(make_beat(odcp_pkg::OP_WRITE, odcp_pkg::SLOT_W'(slot),
                                odcp_pkg::PEN_W'($urandom),
                                odcp_pkg::CHAN_W'($urandom), odcp_pkg::CHAN_W'($urandom),
                                odcp_pkg::CHAN_W'($urandom),
                                odcp_pkg::PHASE_W'($urandom), odcp_pkg::PHASE_W'($urandom)));

        // Directed beats under the reset setting (step 51, six levels)
        push_beat(make_beat(odcp_pkg::OP_WRITE, 8'd0,   8'hA5, 8'd0,   8'd0,   8'd0,
                            4'd0,  4'd0));
        push_beat(make_beat(odcp_pkg::OP_WRITE, 8'd255, 8'hFF, 8'd255, 8'd255, 8'd255,
                            4'd15, 4'd15));
        push_beat(make_beat(odcp_pkg::OP_WRITE, 8'd215, 8'h00, 8'd0,   8'd0,   8'd0,
                            4'd0,  4'd0));
        // black and white at opposite corners of the threshold matrix
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
                            4'd0,  4'd0));
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                            4'd15, 4'd15));
        // largest threshold: nearly everything rounds down
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
                            4'd7, 4'd6));
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0, 8'd254, 8'd101, 8'd50,
                            4'd7, 4'd6));
        // zero threshold: a remainder of one rounds up, zero does not
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0, 8'd51, 8'd52, 8'd0,
                            4'd8, 4'd8));
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0, 8'd204, 8'd205, 8'd1,
                            4'd8, 4'd8));
        // green and blue far apart so the mirrored pen differs
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0, 8'd100, 8'd200, 8'd10,
                            4'd3, 4'd9));
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0, 8'd100, 8'd10, 8'd200,
                            4'd3, 4'd9));
        // overwrite an entry and read it back at once
        push_beat(make_beat(odcp_pkg::OP_WRITE,  8'd0, 8'h3C, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0));
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd0, 8'd0,  8'd0, 8'd0, 8'd0, 4'd0, 4'd0));
        // all-ones slot and value on a dither beat are don't-cares
        push_beat(make_beat(odcp_pkg::OP_DITHER, 8'd255, 8'd255, 8'd30, 8'd130, 8'd230,
                            4'd15, 4'd0));
        push_beat(make_beat(odcp_pkg::OP_WRITE,  8'd255, 8'd0,   8'd0,  8'd0,   8'd0,
                            4'd0,  4'd15));

        run_random(PHASE_ITEMS);

        // Walk the planned settings, then one drawn at random
        for (int p = 0; p < PLAN_LEN; p++)
        begin
            settle();
            write_settings(STEP_PLAN[p], LEVEL_PLAN[p]);
            run_random(PHASE_ITEMS);
        end
        settle();
        write_settings(odcp_pkg::STEP_W'($urandom), odcp_pkg::LEVEL_W'($urandom));
        run_random(PHASE_ITEMS);

        settle();

        $display("Sent %0d pixels and %0d pen table writes over %0d register settings;",
                 pixels_sent, writes_sent, settings_used);
        $display("checked %0d result beats, %0d mismatches.", checked, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
